>>> rtl/core/rsq_pkg.sv
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared types, widths and constants of the rotated sprite quad expander.
// ----------------------------------------------------------------------------
`default_nettype none

package rsq_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int TRIG_FRAC_DEF  = 14;

  localparam int POS_W   = 24;
  localparam int SIZE_W  = 23;
  localparam int ANGLE_W = 16;
  localparam int TEX_W   = 16;
  localparam int COLOR_W = 32;

  localparam int VERTS  = 4;
  localparam int GAP_W  = 2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_W     = 32;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic [CORDIC_W-1:0] ATAN_TBL [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680350,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [1:0] CRN_0 = 2'd0;
  localparam logic [1:0] CRN_1 = 2'd1;
  localparam logic [1:0] CRN_2 = 2'd2;
  localparam logic [1:0] CRN_3 = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic [SIZE_W-1:0]       size_w;
    logic [SIZE_W-1:0]       size_h;
    logic [ANGLE_W-1:0]      angle;
    logic [TEX_W-1:0]        tex_u_left;
    logic [TEX_W-1:0]        tex_u_right;
    logic [TEX_W-1:0]        tex_v_top;
    logic [TEX_W-1:0]        tex_v_bottom;
    logic [COLOR_W-1:0]      color_rgba;
  } rsq_sprite_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic [COLOR_W-1:0]      vertex_color;
    logic [1:0]              corner;
    logic                    last;
  } rsq_vertex_t;

  typedef struct packed {
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic [SIZE_W-1:0]       size_w;
    logic [SIZE_W-1:0]       size_h;
    logic [TEX_W-1:0]        tex_u_left;
    logic [TEX_W-1:0]        tex_u_right;
    logic [TEX_W-1:0]        tex_v_top;
    logic [TEX_W-1:0]        tex_v_bottom;
    logic [COLOR_W-1:0]      color_rgba;
  } rsq_pay_t;

  typedef struct packed {
    rsq_pay_t               pay;
    logic [1:0]             quad;
    logic [CORDIC_FRAC-1:0] z0;
  } rsq_job_t;

endpackage

`default_nettype wire

>>> rtl/core/rsq_front.sv
// ----------------------------------------------------------------------------
// rsq_front
// Takes sprites, splits the angle into quadrant and residual, and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module rsq_front
  import rsq_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire rsq_sprite_t in_sprite,
  output logic             busy,
  input  wire logic        pop,
  output logic             q_valid,
  output rsq_job_t         q_job
);

  localparam logic [31:0] ANGLE_MASK  = (32'd1 << ANGLE_BITS) - 32'd1;
  localparam int          ANGLE_SHIFT = 32 - ANGLE_BITS;
  localparam logic [QPTR_W:0] CNT_FULL = (QPTR_W+1)'(QDEPTH);

  rsq_job_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              push;
  logic [31:0]       angle_turn;
  rsq_job_t          job;

  assign busy    = (cnt_r == CNT_FULL);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_job   = mem_r[rd_ptr_r];

  // classify: quadrant and residual angle in 32-bit turn units
  always_comb begin
    angle_turn            = (32'(in_sprite.angle) & ANGLE_MASK) << ANGLE_SHIFT;
    job.pay.center_x      = in_sprite.center_x;
    job.pay.center_y      = in_sprite.center_y;
    job.pay.size_w        = in_sprite.size_w;
    job.pay.size_h        = in_sprite.size_h;
    job.pay.tex_u_left    = in_sprite.tex_u_left;
    job.pay.tex_u_right   = in_sprite.tex_u_right;
    job.pay.tex_v_top     = in_sprite.tex_v_top;
    job.pay.tex_v_bottom  = in_sprite.tex_v_bottom;
    job.pay.color_rgba    = in_sprite.color_rgba;
    job.quad              = angle_turn[31:30];
    job.z0                = angle_turn[CORDIC_FRAC-1:0];
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rsq_cordic.sv
// ----------------------------------------------------------------------------
// rsq_cordic
// Pops a sprite when the gap counter allows and runs a pipelined rotation
// CORDIC, one step per stage, then rounds, clamps and applies the quadrant.
// ----------------------------------------------------------------------------
`default_nettype none

module rsq_cordic
  import rsq_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_valid,
  input  wire rsq_job_t                           q_job,
  output logic                                    pop,
  output logic                                    trig_valid,
  output logic signed [TRIG_FRAC_BITS+1:0]        trig_cos,
  output logic signed [TRIG_FRAC_BITS+1:0]        trig_sin,
  output rsq_pay_t                                trig_pay
);

  localparam int TW     = TRIG_FRAC_BITS + 2;
  localparam int RND_SH = CORDIC_FRAC - TRIG_FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] RND_HALF = CORDIC_W'(1) << (RND_SH - 1);
  localparam logic signed [CORDIC_W-1:0] T_ONE    = CORDIC_W'(1) << TRIG_FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] T_NONE   = -T_ONE;
  localparam int LASTS  = CORDIC_STEPS - 1;

  function automatic logic signed [TW-1:0] trig_round(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    r = (v + RND_HALF) >>> RND_SH;
    if (r > T_ONE) begin
      r = T_ONE;
    end else if (r < T_NONE) begin
      r = T_NONE;
    end
    return TW'(r);
  endfunction

  logic [GAP_W-1:0]           gap_r, gap_nxt;
  logic signed [CORDIC_W-1:0] x_r [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_r [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] z_r [CORDIC_STEPS];
  logic [1:0]                 quad_r [CORDIC_STEPS];
  rsq_pay_t                   pay_r [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0]    vld_r, vld_nxt;

  logic signed [TW-1:0]       c1_r, s1_r;
  logic [1:0]                 quad1_r;
  rsq_pay_t                   pay1_r;
  logic                       vld1_r;

  logic signed [TW-1:0]       cos_nxt, sin_nxt;
  logic signed [TW-1:0]       cos_r, sin_r;
  rsq_pay_t                   pay2_r;
  logic                       vld2_r;

  // pops are spaced by the gap counter so that each vertex burst has the back end alone
  assign pop = q_valid && (gap_r == '0);

  always_comb begin
    if (pop) begin
      gap_nxt = GAP_W'(VERTS - 1);
    end else if (gap_r != '0) begin
      gap_nxt = gap_r - 1'b1;
    end else begin
      gap_nxt = gap_r;
    end
    vld_nxt = {vld_r[CORDIC_STEPS-2:0], pop};
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0] xi, yi, zi;
    logic [1:0]                 qi;
    rsq_pay_t                   pi;
    logic signed [CORDIC_W-1:0] dx, dy, at;

    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = $signed({2'b00, q_job.z0});
      assign qi = q_job.quad;
      assign pi = q_job.pay;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign qi = quad_r[i-1];
      assign pi = pay_r[i-1];
    end

    assign dx = yi >>> i;
    assign dy = xi >>> i;
    assign at = $signed(ATAN_TBL[i]);

    always_ff @(posedge clk) begin
      if (!zi[CORDIC_W-1]) begin
        x_r[i] <= xi - dx;
        y_r[i] <= yi + dy;
        z_r[i] <= zi - at;
      end else begin
        x_r[i] <= xi + dx;
        y_r[i] <= yi - dy;
        z_r[i] <= zi + at;
      end
      quad_r[i] <= qi;
      pay_r[i]  <= pi;
    end
  end

  always_comb begin
    unique case (quad1_r)
      QUAD_0: begin
        cos_nxt = c1_r;
        sin_nxt = s1_r;
      end
      QUAD_1: begin
        cos_nxt = -s1_r;
        sin_nxt = c1_r;
      end
      QUAD_2: begin
        cos_nxt = -c1_r;
        sin_nxt = -s1_r;
      end
      QUAD_3: begin
        cos_nxt = s1_r;
        sin_nxt = -c1_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    c1_r    <= trig_round(x_r[LASTS]);
    s1_r    <= trig_round(y_r[LASTS]);
    quad1_r <= quad_r[LASTS];
    pay1_r  <= pay_r[LASTS];
    cos_r   <= cos_nxt;
    sin_r   <= sin_nxt;
    pay2_r  <= pay1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r  <= '0;
      vld_r  <= '0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      gap_r  <= gap_nxt;
      vld_r  <= vld_nxt;
      vld1_r <= vld_r[LASTS];
      vld2_r <= vld1_r;
    end
  end

  assign trig_valid = vld2_r;
  assign trig_cos   = cos_r;
  assign trig_sin   = sin_r;
  assign trig_pay   = pay2_r;

endmodule

`default_nettype wire

>>> rtl/core/rsq_expand.sv
// ----------------------------------------------------------------------------
// rsq_expand
// Forms the four rotated corners of a sprite, one vertex per cycle, with
// rounding, centre offset and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module rsq_expand
  import rsq_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               trig_valid,
  input  wire logic signed [TRIG_FRAC_BITS+1:0]   trig_cos,
  input  wire logic signed [TRIG_FRAC_BITS+1:0]   trig_sin,
  input  wire rsq_pay_t                           trig_pay,
  output logic                                    out_valid,
  output rsq_vertex_t                             out_vertex
);

  localparam int TW     = TRIG_FRAC_BITS + 2;
  localparam int PW     = TW + SIZE_W + 1;
  localparam int SW     = PW + 1;
  localparam int OFF_W  = SW - TRIG_FRAC_BITS - 1;
  localparam int PSUM_W = OFF_W + 1;
  localparam logic signed [SW-1:0]     HALF  = SW'(1) << TRIG_FRAC_BITS;
  localparam logic signed [PSUM_W-1:0] P_MAX = PSUM_W'((1 << (POS_W - 1)) - 1);
  localparam logic signed [PSUM_W-1:0] P_MIN = -(PSUM_W'(1 << (POS_W - 1)));

  function automatic logic signed [POS_W-1:0] place(input logic signed [POS_W-1:0] ctr,
                                                   input logic signed [SW-1:0] sum);
    logic signed [SW-1:0]     sh;
    logic signed [PSUM_W-1:0] p;
    sh = sum >>> (TRIG_FRAC_BITS + 1);
    p  = PSUM_W'(ctr) + PSUM_W'($signed(sh[OFF_W-1:0]));
    if (p > P_MAX) begin
      p = P_MAX;
    end else if (p < P_MIN) begin
      p = P_MIN;
    end
    return POS_W'(p);
  endfunction

  // per sprite products
  logic signed [PW-1:0] wc_r, hs_r, ws_r, hc_r;
  rsq_pay_t             hold_r;
  logic                 run_r, run_nxt;
  logic [1:0]           k_r, k_nxt;

  // corner sums
  logic                 neg_x, neg_y;
  logic signed [SW-1:0] xs_nxt, ys_nxt;
  logic signed [SW-1:0] xs_r, ys_r;
  logic signed [POS_W-1:0] cx_r, cy_r;
  logic [TEX_W-1:0]     u_r, v_r;
  logic [COLOR_W-1:0]   col_r;
  logic [1:0]           crn_r;
  logic                 last_r;
  logic                 svld_r;

  rsq_vertex_t          vtx_r;
  logic                 ovld_r;

  always_ff @(posedge clk) begin
    if (trig_valid) begin
      wc_r   <= PW'($signed({1'b0, trig_pay.size_w})) * PW'(trig_cos);
      hs_r   <= PW'($signed({1'b0, trig_pay.size_h})) * PW'(trig_sin);
      ws_r   <= PW'($signed({1'b0, trig_pay.size_w})) * PW'(trig_sin);
      hc_r   <= PW'($signed({1'b0, trig_pay.size_h})) * PW'(trig_cos);
      hold_r <= trig_pay;
    end
  end

  always_comb begin
    if (trig_valid) begin
      run_nxt = 1'b1;
      k_nxt   = CRN_0;
    end else if (run_r) begin
      run_nxt = (k_r != CRN_3);
      k_nxt   = k_r + 1'b1;
    end else begin
      run_nxt = 1'b0;
      k_nxt   = k_r;
    end
  end

  always_comb begin
    neg_x  = (k_r == CRN_0) || (k_r == CRN_3);
    neg_y  = (k_r == CRN_0) || (k_r == CRN_1);
    xs_nxt = (neg_x ? -SW'(wc_r) : SW'(wc_r)) + (neg_y ? SW'(hs_r) : -SW'(hs_r)) + HALF;
    ys_nxt = (neg_x ? -SW'(ws_r) : SW'(ws_r)) + (neg_y ? -SW'(hc_r) : SW'(hc_r)) + HALF;
  end

  always_ff @(posedge clk) begin
    xs_r   <= xs_nxt;
    ys_r   <= ys_nxt;
    cx_r   <= hold_r.center_x;
    cy_r   <= hold_r.center_y;
    u_r    <= neg_x ? hold_r.tex_u_left : hold_r.tex_u_right;
    v_r    <= neg_y ? hold_r.tex_v_bottom : hold_r.tex_v_top;
    col_r  <= hold_r.color_rgba;
    crn_r  <= k_r;
    last_r <= (k_r == CRN_3);

    vtx_r.pos_x        <= place(cx_r, xs_r);
    vtx_r.pos_y        <= place(cy_r, ys_r);
    vtx_r.tex_u        <= u_r;
    vtx_r.tex_v        <= v_r;
    vtx_r.vertex_color <= col_r;
    vtx_r.corner       <= crn_r;
    vtx_r.last         <= last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      k_r    <= CRN_0;
      svld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      k_r    <= k_nxt;
      svld_r <= run_r;
      ovld_r <= svld_r;
    end
  end

  assign out_valid  = ovld_r;
  assign out_vertex = vtx_r;

endmodule

`default_nettype wire

>>> rtl/core/rotated_sprite_quad_expander_unit.sv
// ----------------------------------------------------------------------------
// rotated_sprite_quad_expander_unit
// Expands one rotated, textured sprite into the four vertices of its quad.
// ----------------------------------------------------------------------------
// Input: drive a sprite on in_sprite and raise start; it is taken at a rising
// edge where start is high and busy is low. busy rises only when the four
// entry sprite queue is full.
// Output: four vertices per sprite, corners 0 to 3 in order on consecutive
// cycles, each shown for one cycle with out_valid high; last marks corner 3.
// The receiver cannot stall: vertices must be taken as they come.
// Path: a taken sprite passes the queue, the pipelined CORDIC with one step per
// stage, the rounding and quadrant registers, the per sprite products, the
// corner sums and the output register; the other three follow in the next cycles.
// Pace: set by the single vertex output, as pops are spaced by the gap counter;
// sprites can arrive back to back until the queue fills.
// Reset (rst_n low, synchronous) empties the queue and drops any sprite in
// flight; no vertex is given for it.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_sprite_quad_expander_unit
  import rsq_pkg::*;
#(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire rsq_sprite_t in_sprite,
  output logic             busy,
  output logic             out_valid,
  output rsq_vertex_t      out_vertex
);

  logic                             pop;
  logic                             q_valid;
  rsq_job_t                         q_job;
  logic                             trig_valid;
  logic signed [TRIG_FRAC_BITS+1:0] trig_cos;
  logic signed [TRIG_FRAC_BITS+1:0] trig_sin;
  rsq_pay_t                         trig_pay;

  rsq_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_sprite (in_sprite),
    .busy      (busy),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_job     (q_job)
  );

  rsq_cordic #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_cordic (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .trig_valid (trig_valid),
    .trig_cos   (trig_cos),
    .trig_sin   (trig_sin),
    .trig_pay   (trig_pay)
  );

  rsq_expand #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_expand (
    .clk        (clk),
    .rst_n      (rst_n),
    .trig_valid (trig_valid),
    .trig_cos   (trig_cos),
    .trig_sin   (trig_sin),
    .trig_pay   (trig_pay),
    .out_valid  (out_valid),
    .out_vertex (out_vertex)
  );

endmodule

`default_nettype wire

>>> rtl/core/rsq_checker.sv
// ----------------------------------------------------------------------------
// rsq_checker
// Port level checks on vertex ordering, colour and texture u within a sprite,
// and reset behaviour.
`default_nettype none

module rsq_checker
  import rsq_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire rsq_vertex_t out_vertex
);

  // corners of one sprite come on consecutive cycles
  a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_vertex.corner != CRN_3) |=>
      out_valid && (out_vertex.corner == $past(out_vertex.corner) + 2'd1))
    else $error("corner sequence broken");

  // a new sprite only starts after the previous one ended
  a_corner_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_vertex.corner == CRN_0) |->
      !$past(out_valid) || $past(out_vertex.last))
    else $error("sprite started mid quad");

  // colour is the same on every vertex of a sprite
  a_color_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_vertex.last |=>
      out_vertex.vertex_color == $past(out_vertex.vertex_color))
    else $error("colour changed within sprite");

  // right edge shares u between corners 1 and 2
  a_tex_u_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_vertex.corner == CRN_1) |=>
      out_vertex.tex_u == $past(out_vertex.tex_u))
    else $error("right edge u mismatch");

  // empty after reset
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !busy && !out_valid)
    else $error("not idle after reset");

endmodule

bind rotated_sprite_quad_expander_unit rsq_checker u_rsq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_vertex (out_vertex)
);

`default_nettype wire
